// ===== rtl/gdpc_pkg.sv =====
`default_nettype none

package gdpc_pkg;

    localparam int VALUE_BITS = 40;
    localparam int COUNT_BITS = 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 4'd15;

    localparam int PC_BITS = 5;
    typedef logic [PC_BITS-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_XY,
        OP_SWAP,
        OP_INIT,
        OP_DIV_XD,
        OP_TAKE,
        OP_REDUCE,
        OP_INC_D,
        OP_LEFT,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_DIV_DONE,
        C_Y_ZERO,
        C_X_LT2,
        C_D_GT_Q,
        C_REM_NZ,
        C_OUT_FREE
    } t_cond;

    typedef enum logic {
        K_WAIT,
        K_BRANCH
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_cond cond;
        t_op   op;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic y_zero;
        logic x_lt2;
        logic d_gt_q;
        logic rem_nz;
        logic out_free;
    } t_stat;

    localparam t_pc S_IDLE    = 5'd0;
    localparam t_pc S_TEST_Y  = 5'd1;
    localparam t_pc S_DIV_XY  = 5'd2;
    localparam t_pc S_WAIT_XY = 5'd3;
    localparam t_pc S_SWAP    = 5'd4;
    localparam t_pc S_INIT    = 5'd5;
    localparam t_pc S_TRIAL   = 5'd6;
    localparam t_pc S_WAIT_T  = 5'd7;
    localparam t_pc S_BOUND   = 5'd8;
    localparam t_pc S_HIT     = 5'd9;
    localparam t_pc S_TAKE    = 5'd10;
    localparam t_pc S_DIV_R   = 5'd11;
    localparam t_pc S_WAIT_R  = 5'd12;
    localparam t_pc S_CHECK_R = 5'd13;
    localparam t_pc S_REDUCE  = 5'd14;
    localparam t_pc S_NEXT_D  = 5'd15;
    localparam t_pc S_LEFT    = 5'd16;
    localparam t_pc S_EMIT    = 5'd17;

    // WAIT: hold until cond, then run op and go to target.
    // BRANCH: run op, go to target on cond, else fall through.
    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            S_IDLE:    w = '{K_WAIT,   C_IN_VALID, OP_LOAD,   S_TEST_Y};
            S_TEST_Y:  w = '{K_BRANCH, C_Y_ZERO,   OP_NOP,    S_INIT};
            S_DIV_XY:  w = '{K_BRANCH, C_NEVER,    OP_DIV_XY, S_IDLE};
            S_WAIT_XY: w = '{K_WAIT,   C_DIV_DONE, OP_NOP,    S_SWAP};
            S_SWAP:    w = '{K_BRANCH, C_ALWAYS,   OP_SWAP,   S_TEST_Y};
            S_INIT:    w = '{K_BRANCH, C_X_LT2,    OP_INIT,   S_EMIT};
            S_TRIAL:   w = '{K_BRANCH, C_NEVER,    OP_DIV_XD, S_IDLE};
            S_WAIT_T:  w = '{K_WAIT,   C_DIV_DONE, OP_NOP,    S_BOUND};
            S_BOUND:   w = '{K_BRANCH, C_D_GT_Q,   OP_NOP,    S_LEFT};
            S_HIT:     w = '{K_BRANCH, C_REM_NZ,   OP_NOP,    S_NEXT_D};
            S_TAKE:    w = '{K_BRANCH, C_NEVER,    OP_TAKE,   S_IDLE};
            S_DIV_R:   w = '{K_BRANCH, C_NEVER,    OP_DIV_XD, S_IDLE};
            S_WAIT_R:  w = '{K_WAIT,   C_DIV_DONE, OP_NOP,    S_CHECK_R};
            S_CHECK_R: w = '{K_BRANCH, C_REM_NZ,   OP_NOP,    S_NEXT_D};
            S_REDUCE:  w = '{K_BRANCH, C_ALWAYS,   OP_REDUCE, S_DIV_R};
            S_NEXT_D:  w = '{K_BRANCH, C_ALWAYS,   OP_INC_D,  S_TRIAL};
            S_LEFT:    w = '{K_BRANCH, C_NEVER,    OP_LEFT,   S_IDLE};
            S_EMIT:    w = '{K_WAIT,   C_OUT_FREE, OP_EMIT,   S_IDLE};
            default:   w = '{K_BRANCH, C_ALWAYS,   OP_NOP,    S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + 4'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gcd_distinct_prime_count_core.sv =====
// Counts the distinct prime factors of gcd(first, second) and returns that count plus one.
// Input channel: i_in_valid / o_in_stall with i_first_value and i_second_value; an item
// is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_prime_count_plus_one (saturates at 15).
// One item is worked at a time by a microcoded sequencer driving a shared restoring
// divider that retires one quotient bit per cycle.
// Each Euclid step runs one full division; each trial candidate runs one division, plus
// one more division for each further division by a found factor.
// Latency is therefore data dependent: only the Euclid steps and the emit when the gcd
// is below two, and longest for a prime gcd near 2^40 by default, tried up to its root.
// The result sits in an output register; a new item is taken as soon as the
// previous result is loaded there, even while the receiver stalls it.
// If the output register is still full when the next result is ready, the
// sequencer holds at its last step until the receiver takes the older item.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
// output register; no other state survives between items.
`default_nettype none

module gcd_distinct_prime_count_core #(
    parameter int VALUE_BITS = gdpc_pkg::VALUE_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic     [VALUE_BITS-1:0]          i_first_value,
    input  wire logic     [VALUE_BITS-1:0]          i_second_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [gdpc_pkg::COUNT_BITS-1:0]         o_prime_count_plus_one
);

    gdpc_pkg::t_op   w_op;
    gdpc_pkg::t_stat w_stat;

    gdpc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_op       (w_op),
        .o_in_stall (o_in_stall)
    );

    gdpc_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_in_valid     (i_in_valid),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_count        (o_prime_count_plus_one),
        .o_stat         (w_stat)
    );

endmodule

`default_nettype wire

// ===== rtl/gdpc_div.sv =====
`default_nettype none

module gdpc_div #(
    parameter int VALUE_BITS = gdpc_pkg::VALUE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [VALUE_BITS-1:0] i_divisor,
    output logic                       o_busy,
    output logic      [VALUE_BITS-1:0] o_quo,
    output logic      [VALUE_BITS-1:0] o_rem
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  r_busy, n_busy;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [VALUE_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_div, n_div;
    logic [VALUE_BITS:0]   w_trial;
    logic [VALUE_BITS:0]   w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(VALUE_BITS);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[VALUE_BITS-1:0] : w_trial[VALUE_BITS-1:0];
            n_quo = {r_quo[VALUE_BITS-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/gdpc_dp.sv =====
`default_nettype none

module gdpc_dp #(
    parameter int VALUE_BITS = gdpc_pkg::VALUE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gdpc_pkg::t_op                 i_op,
    input  wire logic                          i_in_valid,
    input  wire logic     [VALUE_BITS-1:0]     i_first_value,
    input  wire logic     [VALUE_BITS-1:0]     i_second_value,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [gdpc_pkg::COUNT_BITS-1:0]    o_count,
    output gdpc_pkg::t_stat                    o_stat
);

    logic [VALUE_BITS-1:0]           r_x, n_x;
    logic [VALUE_BITS-1:0]           r_y, n_y;
    logic [VALUE_BITS-1:0]           r_d, n_d;
    logic [gdpc_pkg::COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [gdpc_pkg::COUNT_BITS-1:0] r_out, n_out;
    logic                            r_out_valid, n_out_valid;
    logic                            w_start;
    logic [VALUE_BITS-1:0]           w_divisor;
    logic                            w_busy;
    logic [VALUE_BITS-1:0]           w_quo;
    logic [VALUE_BITS-1:0]           w_rem;
    logic                            w_x_lt2;

    assign w_start   = (i_op == gdpc_pkg::OP_DIV_XY) || (i_op == gdpc_pkg::OP_DIV_XD);
    assign w_divisor = (i_op == gdpc_pkg::OP_DIV_XY) ? r_y : r_d;
    assign w_x_lt2   = (r_x >> 1) == '0;

    gdpc_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_x),
        .i_divisor  (w_divisor),
        .o_busy     (w_busy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_d = r_d;
        n_cnt = r_cnt;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (i_op)
            gdpc_pkg::OP_LOAD: begin
                n_x = i_first_value;
                n_y = i_second_value;
            end
            gdpc_pkg::OP_SWAP: begin
                n_x = r_y;
                n_y = w_rem;
            end
            gdpc_pkg::OP_INIT: begin
                n_cnt = '0;
                n_d   = VALUE_BITS'(2);
            end
            gdpc_pkg::OP_TAKE: begin
                n_x   = w_quo;
                n_cnt = gdpc_pkg::sat_inc(r_cnt);
            end
            gdpc_pkg::OP_REDUCE: begin
                n_x = w_quo;
            end
            gdpc_pkg::OP_INC_D: begin
                n_d = r_d + 1'b1;
            end
            gdpc_pkg::OP_LEFT: begin
                if (!w_x_lt2) begin
                    n_cnt = gdpc_pkg::sat_inc(r_cnt);
                end
            end
            gdpc_pkg::OP_EMIT: begin
                n_out       = gdpc_pkg::sat_inc(r_cnt);
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_d   <= n_d;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_count     = r_out;

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.div_done = !w_busy;
    assign o_stat.y_zero   = r_y == '0;
    assign o_stat.x_lt2    = w_x_lt2;
    assign o_stat.d_gt_q   = r_d > w_quo;
    assign o_stat.rem_nz   = w_rem != '0;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// ===== rtl/gdpc_seq.sv =====
`default_nettype none

module gdpc_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gdpc_pkg::t_stat i_stat,
    output gdpc_pkg::t_op        o_op,
    output logic                 o_in_stall
);

    gdpc_pkg::t_pc    r_pc, n_pc;
    gdpc_pkg::t_uword w_word;
    logic             w_cond;
    logic             w_fire;

    assign w_word = gdpc_pkg::ucode(r_pc);

    always_comb begin
        case (w_word.cond)
            gdpc_pkg::C_NEVER:    w_cond = 1'b0;
            gdpc_pkg::C_ALWAYS:   w_cond = 1'b1;
            gdpc_pkg::C_IN_VALID: w_cond = i_stat.in_valid;
            gdpc_pkg::C_DIV_DONE: w_cond = i_stat.div_done;
            gdpc_pkg::C_Y_ZERO:   w_cond = i_stat.y_zero;
            gdpc_pkg::C_X_LT2:    w_cond = i_stat.x_lt2;
            gdpc_pkg::C_D_GT_Q:   w_cond = i_stat.d_gt_q;
            gdpc_pkg::C_REM_NZ:   w_cond = i_stat.rem_nz;
            gdpc_pkg::C_OUT_FREE: w_cond = i_stat.out_free;
            default:              w_cond = 1'b0;
        endcase
    end

    assign w_fire = (w_word.kind == gdpc_pkg::K_BRANCH) || w_cond;

    always_comb begin
        if (w_cond) begin
            n_pc = w_word.target;
        end else if (w_word.kind == gdpc_pkg::K_BRANCH) begin
            n_pc = r_pc + 1'b1;
        end else begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= gdpc_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op       = w_fire ? w_word.op : gdpc_pkg::OP_NOP;
    assign o_in_stall = r_pc != gdpc_pkg::S_IDLE;

endmodule

`default_nettype wire

// ===== rtl/gdpc_checker.sv =====
`default_nettype none

module gdpc_checker #(
    parameter int VALUE_BITS = gdpc_pkg::VALUE_BITS
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic [VALUE_BITS-1:0]          i_first_value,
    input wire logic [VALUE_BITS-1:0]          i_second_value,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [gdpc_pkg::COUNT_BITS-1:0] o_prime_count_plus_one
);

    logic w_operands_seen;

    assign w_operands_seen = (|i_first_value) || (|i_second_value) || 1'b1;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && w_operands_seen |=> o_in_stall)
        else $error("item taken while another is in work");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_prime_count_plus_one != '0)
        else $error("result below one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_prime_count_plus_one))
        else $error("stalled result changed");

endmodule

bind gcd_distinct_prime_count_core gdpc_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_gdpc_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_in_valid             (i_in_valid),
    .o_in_stall             (o_in_stall),
    .i_first_value          (i_first_value),
    .i_second_value         (i_second_value),
    .o_out_valid            (o_out_valid),
    .i_out_stall            (i_out_stall),
    .o_prime_count_plus_one (o_prime_count_plus_one)
);

`default_nettype wire
